/* hw/rtl/bounded_max_xor_trie_assert.svh */
// assertion macros for the bounded max-xor trie
`ifndef BOUNDED_MAX_XOR_TRIE_ASSERT_SVH
`define BOUNDED_MAX_XOR_TRIE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BMXT_HOLDS(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bmxt same-cycle check failed");

// next-cycle implication, checked out of reset
`define BMXT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bmxt next-cycle check failed");

`endif

/* hw/rtl/bmxt_pkg.sv */
// types and constants of the bounded max-xor trie
package bmxt_pkg;

  localparam int KEY_BITS   = 32;
  localparam int NODE_COUNT = 4096;
  localparam int DATA_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int CNT_W      = $clog2(NODE_COUNT + 1);
  localparam int LVL_W      = $clog2(KEY_BITS);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [NODE_W-1:0]   node_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [LVL_W-1:0]    lvl_t;

  // node entry: links to both children and the subtree minimum under each
  typedef struct packed {
    node_t c0;
    node_t c1;
    key_t  m0;
    key_t  m1;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CHECK,
    S_INS_WALK,
    S_QRY_WALK,
    S_RESP
  } state_t;

endpackage

/* hw/rtl/bmxt_if.sv */
// valid/ready channel interfaces of the bounded max-xor trie
interface bmxt_in_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [bmxt_pkg::DATA_W-1:0] value;
  logic [bmxt_pkg::DATA_W-1:0] limit;

  modport source (output valid, output cmd, output value, output limit, input ready);
  modport sink   (input valid, input cmd, input value, input limit, output ready);
endinterface

interface bmxt_out_if;
  logic                         valid;
  logic                         ready;
  logic [bmxt_pkg::STATUS_W-1:0] status;
  logic [bmxt_pkg::DATA_W-1:0]   xor_value;

  modport source (output valid, output status, output xor_value, input ready);
  modport sink   (input valid, input status, input xor_value, output ready);
endinterface

/* hw/rtl/bounded_max_xor_trie.sv */
// bounded max-xor trie: inserts keys and answers limited max-xor queries
// in_ch carries one command per transfer: insert value, or query key value
// against stored values no greater than limit. out_ch returns one result per
// command: status (done, no value within limit, node store full) and xor_value.
// the block takes one command at a time; in_ch.ready is high only when idle.
// an item walks the trie one level per cycle, one read of the node memory per
// key bit, before the result is set up in S_RESP. a query on an empty trie
// or with all values above the limit goes straight to S_RESP; a query may
// also end early on a broken path. while fewer than KEY_BITS nodes remain
// free an insert first walks the path read-only to count the nodes it needs.
// the result waits in an output register; a command can be accepted while it
// waits, and a finished result holds in the block until out_ch.ready frees it.
// reset empties the trie (root without children, node count one); the node
// memory itself is not cleared, entries are written when nodes are allocated.
module bounded_max_xor_trie (
  input  logic              clk,
  input  logic              rst_n,
  bmxt_in_if.sink           in_ch,
  bmxt_out_if.source        out_ch
);

  localparam bmxt_pkg::lvl_t LVL_TOP = bmxt_pkg::LVL_W'(bmxt_pkg::KEY_BITS - 1);

  bmxt_pkg::state_t state_r, state_nxt;

  bmxt_pkg::entry_t root_r, root_nxt;
  bmxt_pkg::key_t   root_min_r, root_min_nxt;
  bmxt_pkg::cnt_t   nodes_used_r, nodes_used_nxt;

  bmxt_pkg::key_t   key_r, key_nxt;
  logic [bmxt_pkg::DATA_W-1:0] lim_r, lim_nxt;
  bmxt_pkg::lvl_t   lvl_r, lvl_nxt;
  bmxt_pkg::node_t  cur_r, cur_nxt;
  logic             fresh_r, fresh_nxt;
  bmxt_pkg::key_t   acc_r, acc_nxt;
  logic [bmxt_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [bmxt_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [bmxt_pkg::DATA_W-1:0]   out_xor_r, out_xor_nxt;

  // node memory; node 0 lives in root_r
  bmxt_pkg::entry_t mem [bmxt_pkg::NODE_COUNT];
  bmxt_pkg::entry_t rdata_r;
  logic             mem_we;
  bmxt_pkg::node_t  mem_waddr;
  bmxt_pkg::entry_t mem_wdata;
  bmxt_pkg::node_t  rd_addr;

  bmxt_pkg::entry_t cur_e;
  bmxt_pkg::entry_t upd_e;
  logic             bit_b;
  bmxt_pkg::node_t  same_c, opp_c;
  bmxt_pkg::key_t   same_m, opp_m;
  logic             last;
  logic             go_opp;
  bmxt_pkg::cnt_t   remaining;
  bmxt_pkg::cnt_t   missing;
  bmxt_pkg::node_t  alloc_id;
  logic             in_xfer;
  logic             out_free;
  bmxt_pkg::key_t   in_key;
  logic             q_empty;
  logic             low_nodes;

  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_key    = in_ch.value[bmxt_pkg::KEY_BITS-1:0];
  assign q_empty   = (nodes_used_r <= bmxt_pkg::CNT_W'(1)) || (root_min_r > in_ch.limit);
  assign remaining = bmxt_pkg::CNT_W'(bmxt_pkg::NODE_COUNT) - nodes_used_r;
  assign low_nodes = remaining < bmxt_pkg::CNT_W'(bmxt_pkg::KEY_BITS);
  assign missing   = bmxt_pkg::CNT_W'(lvl_r) + bmxt_pkg::CNT_W'(1);
  assign alloc_id  = nodes_used_r[bmxt_pkg::NODE_W-1:0];

  assign cur_e  = (cur_r == '0) ? root_r : rdata_r;
  assign bit_b  = key_r[lvl_r];
  assign same_c = bit_b ? cur_e.c1 : cur_e.c0;
  assign same_m = bit_b ? cur_e.m1 : cur_e.m0;
  assign opp_c  = bit_b ? cur_e.c0 : cur_e.c1;
  assign opp_m  = bit_b ? cur_e.m0 : cur_e.m1;
  assign last   = (lvl_r == '0);
  assign go_opp = (opp_c != '0) && (opp_m <= lim_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bmxt_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (in_ch.cmd == bmxt_pkg::CMD_QUERY) begin
            state_nxt = q_empty ? bmxt_pkg::S_RESP : bmxt_pkg::S_QRY_WALK;
          end else begin
            state_nxt = low_nodes ? bmxt_pkg::S_INS_CHECK : bmxt_pkg::S_INS_WALK;
          end
        end
      end
      bmxt_pkg::S_INS_CHECK: begin
        if (same_c == '0) begin
          state_nxt = (missing > remaining) ? bmxt_pkg::S_RESP : bmxt_pkg::S_INS_WALK;
        end else if (last) begin
          state_nxt = bmxt_pkg::S_INS_WALK;
        end
      end
      bmxt_pkg::S_INS_WALK: begin
        if (last) begin
          state_nxt = bmxt_pkg::S_RESP;
        end
      end
      bmxt_pkg::S_QRY_WALK: begin
        if (last || (!go_opp && same_c == '0)) begin
          state_nxt = bmxt_pkg::S_RESP;
        end
      end
      bmxt_pkg::S_RESP: begin
        if (out_free) begin
          state_nxt = bmxt_pkg::S_IDLE;
        end
      end
      default: state_nxt = bmxt_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    root_nxt       = root_r;
    root_min_nxt   = root_min_r;
    nodes_used_nxt = nodes_used_r;
    key_nxt        = key_r;
    lim_nxt        = lim_r;
    lvl_nxt        = lvl_r;
    cur_nxt        = cur_r;
    fresh_nxt      = fresh_r;
    acc_nxt        = acc_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_xor_nxt    = out_xor_r;
    mem_we         = 1'b0;
    mem_waddr      = cur_r;
    rd_addr        = cur_r;
    upd_e          = cur_e;
    mem_wdata      = upd_e;

    case (state_r)
      bmxt_pkg::S_IDLE: begin
        if (in_xfer) begin
          key_nxt        = in_key;
          lim_nxt        = in_ch.limit;
          lvl_nxt        = LVL_TOP;
          cur_nxt        = '0;
          fresh_nxt      = 1'b0;
          acc_nxt        = '0;
          res_status_nxt = ((in_ch.cmd == bmxt_pkg::CMD_QUERY) && q_empty) ?
                           bmxt_pkg::ST_EMPTY : bmxt_pkg::ST_DONE;
        end
      end
      bmxt_pkg::S_INS_CHECK: begin
        if (same_c == '0 || last) begin
          cur_nxt = '0;
          lvl_nxt = LVL_TOP;
          if (same_c == '0 && missing > remaining) begin
            res_status_nxt = bmxt_pkg::ST_FULL;
          end
        end else begin
          cur_nxt = same_c;
          rd_addr = same_c;
          lvl_nxt = lvl_r - 1'b1;
        end
      end
      bmxt_pkg::S_INS_WALK: begin
        if (lvl_r == LVL_TOP && key_r < root_min_r) begin
          root_min_nxt = key_r;
        end
        if (fresh_r) begin
          upd_e = '0;
        end
        if (!fresh_r && same_c != '0) begin
          if (bit_b) begin
            upd_e.m1 = (key_r < same_m) ? key_r : same_m;
          end else begin
            upd_e.m0 = (key_r < same_m) ? key_r : same_m;
          end
          cur_nxt = same_c;
          rd_addr = same_c;
        end else begin
          if (bit_b) begin
            upd_e.c1 = alloc_id;
            upd_e.m1 = key_r;
          end else begin
            upd_e.c0 = alloc_id;
            upd_e.m0 = key_r;
          end
          nodes_used_nxt = nodes_used_r + 1'b1;
          cur_nxt        = alloc_id;
          fresh_nxt      = 1'b1;
        end
        mem_wdata = upd_e;
        if (cur_r == '0) begin
          root_nxt = upd_e;
        end else begin
          mem_we = 1'b1;
        end
        if (!last) begin
          lvl_nxt = lvl_r - 1'b1;
        end
      end
      bmxt_pkg::S_QRY_WALK: begin
        if (go_opp) begin
          acc_nxt[lvl_r] = 1'b1;
          cur_nxt        = opp_c;
          rd_addr        = opp_c;
        end else if (same_c != '0) begin
          cur_nxt = same_c;
          rd_addr = same_c;
        end
        if (!last) begin
          lvl_nxt = lvl_r - 1'b1;
        end
      end
      bmxt_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_xor_nxt    = (res_status_r == bmxt_pkg::ST_DONE) ?
                           bmxt_pkg::DATA_W'(acc_r) : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bmxt_pkg::S_IDLE;
      root_r       <= '0;
      root_min_r   <= '1;
      nodes_used_r <= bmxt_pkg::CNT_W'(1);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      root_r       <= root_nxt;
      root_min_r   <= root_min_nxt;
      nodes_used_r <= nodes_used_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    lim_r        <= lim_nxt;
    lvl_r        <= lvl_nxt;
    cur_r        <= cur_nxt;
    fresh_r      <= fresh_nxt;
    acc_r        <= acc_nxt;
    res_status_r <= res_status_nxt;
    out_status_r <= out_status_nxt;
    out_xor_r    <= out_xor_nxt;
  end

  assign in_ch.ready      = (state_r == bmxt_pkg::S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.xor_value = out_xor_r;

endmodule

/* hw/rtl/bmxt_checker.sv */
// port-level checks of the bounded max-xor trie and their bind
`include "bounded_max_xor_trie_assert.svh"

module bmxt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bmxt_pkg::STATUS_W-1:0] out_status,
  input logic [bmxt_pkg::DATA_W-1:0]   out_xor_value
);

  logic out_stall;
  logic out_not_done;
  logic in_xfer;
  logic status_known;

  assign out_stall    = out_valid && !out_ready;
  assign out_not_done = out_valid && (out_status != bmxt_pkg::ST_DONE);
  assign in_xfer      = in_valid && in_ready;
  assign status_known = (out_status == bmxt_pkg::ST_DONE) ||
                        (out_status == bmxt_pkg::ST_EMPTY) ||
                        (out_status == bmxt_pkg::ST_FULL);

  // a stalled result holds
  `BMXT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_status) && $stable(out_xor_value))

  // any result whose status is not done reports a zero xor
  `BMXT_HOLDS(a_xor_zero, out_not_done, out_xor_value == '0)

  // one command at a time: the input closes after each transfer
  `BMXT_NEXT(a_one_at_a_time, in_xfer, !in_ready)

  // the status code stays within its three meanings
  `BMXT_HOLDS(a_status_code, out_valid, status_known)

endmodule

bind bounded_max_xor_trie bmxt_checker u_bmxt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_status    (out_ch.status),
  .out_xor_value (out_ch.xor_value)
);

/* tb/testbench.sv */
`timescale 1ns / 100ps
// self-checking testbench of the bounded max-xor trie: directed table, then random traffic
module testbench;

  localparam int KEY_BITS   = bmxt_pkg::KEY_BITS;
  localparam int NODE_COUNT = bmxt_pkg::NODE_COUNT;
  localparam int STATUS_W   = bmxt_pkg::STATUS_W;

  localparam logic CMD_INSERT = bmxt_pkg::CMD_INSERT;
  localparam logic CMD_QUERY  = bmxt_pkg::CMD_QUERY;

  localparam logic [STATUS_W-1:0] ST_DONE  = bmxt_pkg::ST_DONE;
  localparam logic [STATUS_W-1:0] ST_EMPTY = bmxt_pkg::ST_EMPTY;
  localparam logic [STATUS_W-1:0] ST_FULL  = bmxt_pkg::ST_FULL;

  typedef bmxt_pkg::key_t  key_t;
  typedef bmxt_pkg::node_t node_t;

  localparam int IDLE_PCT    = 22;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 4 * (KEY_BITS + 2);
  localparam int PRINT_CAP   = 200;

  typedef struct {
    logic [STATUS_W-1:0] status;
    key_t                xor_value;
  } answer_t;

  typedef struct {
    logic    cmd;
    key_t    value;
    key_t    limit;
    bit      typed;
    answer_t answer;
  } drill_t;

  logic clk = 1'b0;
  logic rst_n;
  logic steady = 1'b0;
  int   mismatches = 0;
  int   quiet_cycles = 0;

  node_t link0 [NODE_COUNT];
  node_t link1 [NODE_COUNT];
  key_t  sub_min [NODE_COUNT];
  int    node_total;

  answer_t pending_answers [$];
  key_t    kept_values [$];
  key_t    prefixes [8];
  drill_t  drills [$];

  bmxt_in_if  in_ch ();
  bmxt_out_if out_ch ();

  bounded_max_xor_trie i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  function automatic logic [STATUS_W-1:0] trie_insert(input key_t v);
    int    node;
    int    missing;
    bit    off_path;
    node_t c;
    node = 0;
    missing = 0;
    off_path = 1'b0;
    for (int i = KEY_BITS - 1; i >= 0; i--) begin
      if (!off_path) begin
        c = v[i] ? link1[node] : link0[node];
        if (c == '0) off_path = 1'b1;
        else node = c;
      end
      if (off_path) missing++;
    end
    if (missing > NODE_COUNT - node_total) return ST_FULL;
    if (v < sub_min[0]) sub_min[0] = v;
    node = 0;
    for (int i = KEY_BITS - 1; i >= 0; i--) begin
      c = v[i] ? link1[node] : link0[node];
      if (c == '0) begin
        c = node_t'(node_total);
        node_total++;
        link0[c] = '0;
        link1[c] = '0;
        sub_min[c] = v;
        if (v[i]) link1[node] = c;
        else link0[node] = c;
      end else if (v < sub_min[c]) begin
        sub_min[c] = v;
      end
      node = c;
    end
    kept_values.insert(kept_values.size(), v);
    return ST_DONE;
  endfunction

  function automatic answer_t trie_query(input key_t key, input key_t lim);
    answer_t a;
    int      node;
    node_t   t;
    node_t   s;
    a.status = ST_EMPTY;
    a.xor_value = '0;
    if (node_total <= 1 || sub_min[0] > lim) return a;
    a.status = ST_DONE;
    node = 0;
    for (int i = KEY_BITS - 1; i >= 0; i--) begin
      t = key[i] ? link0[node] : link1[node];
      s = key[i] ? link1[node] : link0[node];
      if (t != '0 && sub_min[t] <= lim) begin
        a.xor_value[i] = 1'b1;
        node = t;
      end else if (s == '0) begin
        break;
      end else begin
        node = s;
      end
    end
    return a;
  endfunction

  function automatic answer_t predict_answer(input logic cmd, input key_t v, input key_t lim);
    answer_t a;
    if (cmd == CMD_INSERT) begin
      a.status = trie_insert(v);
      a.xor_value = '0;
    end else begin
      a = trie_query(v, lim);
    end
    return a;
  endfunction

  function automatic void add_drill(input logic cmd, input key_t v, input key_t lim,
                                    input bit typed, input logic [STATUS_W-1:0] st,
                                    input key_t xv);
    drill_t d;
    d.cmd = cmd;
    d.value = v;
    d.limit = lim;
    d.typed = typed;
    d.answer.status = st;
    d.answer.xor_value = xv;
    drills.insert(drills.size(), d);
  endfunction

  function automatic key_t pick_kept();
    if (kept_values.size() == 0) return key_t'($urandom);
    return kept_values[$urandom_range(kept_values.size() - 1)];
  endfunction

  function automatic key_t cluster_value();
    return {prefixes[$urandom_range(7)][KEY_BITS-1:12], 12'($urandom)};
  endfunction

  function automatic key_t pick_key();
    case ($urandom_range(2))
      0:       return cluster_value();
      1:       return key_t'($urandom);
      default: return pick_kept();
    endcase
  endfunction

  function automatic key_t pick_limit();
    case ($urandom_range(5))
      0:       return '1;
      1:       return key_t'($urandom_range(15));
      2:       return key_t'($urandom);
      3:       return pick_kept();
      4:       return pick_kept() - 1;
      default: return pick_kept() + key_t'($urandom_range(3));
    endcase
  endfunction

  function automatic key_t fill_value();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return key_t'($urandom);
      5, 6, 7:       return pick_kept() ^
                            (key_t'($urandom) & ((key_t'(1) << $urandom_range(1, 8)) - 1));
      default:       return pick_kept();
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    if (mismatches < PRINT_CAP) $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic transfer_item(input logic cmd, input key_t value, input key_t limit,
                               input bit typed, input answer_t typed_answer);
    answer_t predicted;
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= cmd;
    in_ch.value <= value;
    in_ch.limit <= limit;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = predict_answer(cmd, value, limit);
    pending_answers.insert(pending_answers.size(), typed ? typed_answer : predicted);
  endtask

  task automatic random_item(input bit filling);
    answer_t none;
    none.status = ST_DONE;
    none.xor_value = '0;
    if (!filling && $urandom_range(99) < 40)
      transfer_item(CMD_INSERT, cluster_value(), key_t'($urandom), 1'b0, none);
    else if (filling && $urandom_range(99) < 60)
      transfer_item(CMD_INSERT, fill_value(), key_t'($urandom), 1'b0, none);
    else
      transfer_item(CMD_QUERY, pick_key(), pick_limit(), 1'b0, none);
  endtask

  always @(negedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_answers.size() == 0) begin
        flag_mismatch($sformatf("unexpected result status %0d xor %h",
                                out_ch.status, out_ch.xor_value));
      end else begin
        want = pending_answers.pop_front();
        if (out_ch.status !== want.status)
          flag_mismatch($sformatf("status %0d, predicted %0d", out_ch.status, want.status));
        if (out_ch.xor_value !== want.xor_value)
          flag_mismatch($sformatf("xor_value %h, predicted %h",
                                  out_ch.xor_value, want.xor_value));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.cmd    = CMD_INSERT;
    in_ch.value  = '0;
    in_ch.limit  = '0;

    for (int i = 0; i < NODE_COUNT; i++) begin
      link0[i] = '0;
      link1[i] = '0;
      sub_min[i] = '0;
    end
    sub_min[0] = '1;
    node_total = 1;

    prefixes[0] = '0;
    prefixes[1] = '1;
    for (int i = 2; i < 8; i++) prefixes[i] = key_t'($urandom);

    // empty trie, then a lone value above the limit
    add_drill(CMD_QUERY,  32'h0000_0000, 32'hFFFF_FFFF, 1, ST_EMPTY, '0);
    add_drill(CMD_QUERY,  32'hFFFF_FFFF, 32'h0000_0000, 1, ST_EMPTY, '0);
    add_drill(CMD_INSERT, 32'h8000_0000, 32'h0000_0000, 1, ST_DONE, '0);
    add_drill(CMD_QUERY,  32'h0000_0000, 32'h7FFF_FFFF, 1, ST_EMPTY, '0);
    add_drill(CMD_QUERY,  32'h0000_0000, 32'h8000_0000, 1, ST_DONE, 32'h8000_0000);
    add_drill(CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 1, ST_DONE, '0);
    add_drill(CMD_QUERY,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_DONE, 32'hFFFF_FFFF);
    add_drill(CMD_QUERY,  32'hFFFF_FFFF, 32'h0000_0000, 1, ST_DONE, 32'hFFFF_FFFF);
    add_drill(CMD_QUERY,  32'h0000_0000, 32'h0000_0000, 1, ST_DONE, '0);
    add_drill(CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 1, ST_DONE, '0);
    add_drill(CMD_QUERY,  32'h0000_0000, 32'hFFFF_FFFF, 1, ST_DONE, 32'hFFFF_FFFF);
    add_drill(CMD_QUERY,  32'h0000_0000, 32'hFFFF_FFFE, 1, ST_DONE, 32'h8000_0000);
    // duplicate insert
    add_drill(CMD_INSERT, 32'h0000_0000, 32'h1234_5678, 1, ST_DONE, '0);
    add_drill(CMD_INSERT, 32'h5555_5555, 32'h0000_0000, 0, ST_DONE, '0);
    add_drill(CMD_INSERT, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 0, ST_DONE, '0);
    add_drill(CMD_QUERY,  32'h5555_5555, 32'hFFFF_FFFF, 0, ST_DONE, '0);
    add_drill(CMD_QUERY,  32'hAAAA_AAAA, 32'h5555_5555, 0, ST_DONE, '0);
    add_drill(CMD_QUERY,  32'h1234_5678, 32'h5555_5554, 0, ST_DONE, '0);
    add_drill(CMD_INSERT, 32'h0000_0001, 32'h0000_0000, 0, ST_DONE, '0);
    add_drill(CMD_QUERY,  32'h0000_0001, 32'h0000_0001, 0, ST_DONE, '0);
    add_drill(CMD_QUERY,  32'h7FFF_FFFF, 32'h8000_0000, 0, ST_DONE, '0);
    add_drill(CMD_QUERY,  32'h8000_0000, 32'h7FFF_FFFF, 0, ST_DONE, '0);

    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (drills[k])
      transfer_item(drills[k].cmd, drills[k].value, drills[k].limit,
                    drills[k].typed, drills[k].answer);

    // clustered values keep the trie well below its node budget
    repeat (650) random_item(1'b0);

    // hold off until every result has come back
    @(negedge clk) in_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);

    // no idling on either side
    steady = 1'b1;
    repeat (200) random_item(1'b0);
    steady = 1'b0;

    // wide random values run the node store out
    repeat (580) random_item(1'b1);

    @(negedge clk) in_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
